[hdl/p3a_pkg.sv]
// ----------------------------------------------------------------------------
// p3a_pkg
// Shared constants and types for the planar three-joint arm pose block.
// ----------------------------------------------------------------------------
package p3a_pkg;

  localparam int ANGLE_BITS_DEF  = 16;
  localparam int LENGTH_BITS_DEF = 16;
  localparam int TRIG_STAGES_DEF = 16;
  localparam int ATAN_ENTRIES    = 24;

  localparam int CORDIC_W = 34;
  localparam logic signed [CORDIC_W-1:0] CORDIC_GAIN = 34'sd652032874;

  localparam logic [1:0] REG_LINK_ONE   = 2'd0;
  localparam logic [1:0] REG_LINK_TWO   = 2'd1;
  localparam logic [1:0] REG_LINK_THREE = 2'd2;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [32:0]         z;
  } p3a_rot_t;

  function automatic logic signed [32:0] atan_phase(input int idx);
    logic signed [32:0] v;
    case (idx)
      0: v = 33'sd536870912;   1: v = 33'sd316933406;
      2: v = 33'sd167458907;   3: v = 33'sd85004756;
      4: v = 33'sd42667331;    5: v = 33'sd21354465;
      6: v = 33'sd10680862;    7: v = 33'sd5340245;
      8: v = 33'sd2670163;     9: v = 33'sd1335087;
      10: v = 33'sd667544;     11: v = 33'sd333772;
      12: v = 33'sd166886;     13: v = 33'sd83443;
      14: v = 33'sd41722;      15: v = 33'sd20861;
      16: v = 33'sd10430;      17: v = 33'sd5215;
      18: v = 33'sd2608;       19: v = 33'sd1304;
      20: v = 33'sd652;        21: v = 33'sd326;
      22: v = 33'sd163;        23: v = 33'sd81;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

[hdl/planar_three_joint_arm_pose_top.sv]
// ----------------------------------------------------------------------------
// planar_three_joint_arm_pose_top
// Forward kinematics of a planar three-joint arm.
// ----------------------------------------------------------------------------
// Accepts one joint word per cycle while in_stall is low and returns one pose
// word per joint word, in order. Each word passes the angle-sum registers,
// the CORDIC fold register, cell chain (stage count capped at 24) and rounding
// register, then the product and sum registers. The whole pipeline advances
// only when the output stage is free, so a stalled output holds every stage.
module planar_three_joint_arm_pose_top #(
  parameter int ANGLE_BITS  = p3a_pkg::ANGLE_BITS_DEF,
  parameter int LENGTH_BITS = p3a_pkg::LENGTH_BITS_DEF,
  parameter int TRIG_STAGES = p3a_pkg::TRIG_STAGES_DEF
) (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         cfg_we,
  input  logic [1:0]                   cfg_index,
  input  logic [LENGTH_BITS-1:0]       cfg_data,
  input  logic                         in_valid,
  output logic                         in_stall,
  input  logic signed [ANGLE_BITS-1:0] in_joint_one_angle,
  input  logic signed [ANGLE_BITS-1:0] in_joint_two_angle,
  input  logic signed [ANGLE_BITS-1:0] in_joint_three_angle,
  output logic                         out_valid,
  input  logic                         out_stall,
  output logic signed [LENGTH_BITS+2:0] out_pose_x,
  output logic signed [LENGTH_BITS+2:0] out_pose_y,
  output logic signed [ANGLE_BITS-1:0] out_pose_heading
);

  localparam int STAGES = (TRIG_STAGES < p3a_pkg::ATAN_ENTRIES) ?
                          TRIG_STAGES : p3a_pkg::ATAN_ENTRIES;
  localparam int LAT = STAGES + 5;
  localparam int PW = LENGTH_BITS + 17;
  localparam logic signed [PW-1:0] RND = PW'(16384);

  logic [LENGTH_BITS-1:0] len_r [3];
  logic [LAT-1:0] vld_r;
  logic [ANGLE_BITS-1:0] ang_r [3];
  logic [ANGLE_BITS-1:0] head_r [LAT];
  logic signed [15:0] cs [3];
  logic signed [15:0] sn [3];
  logic signed [PW-1:0] px_r [3];
  logic signed [PW-1:0] py_r [3];
  logic signed [LENGTH_BITS+2:0] sx_r, sy_r;
  logic adv;

  // Stall-free advance: gate the clock enable of the whole pipe on the output.
  assign adv = !(out_valid && out_stall);
  assign in_stall = !adv;
  assign out_valid = vld_r[LAT-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_r[0] <= '0; len_r[1] <= '0; len_r[2] <= '0;
      vld_r <= '0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          p3a_pkg::REG_LINK_ONE:   len_r[0] <= cfg_data;
          p3a_pkg::REG_LINK_TWO:   len_r[1] <= cfg_data;
          p3a_pkg::REG_LINK_THREE: len_r[2] <= cfg_data;
          default: ;
        endcase
      end
      if (adv) vld_r <= {vld_r[LAT-2:0], in_valid};
    end
  end

  // Advance every stage of the pipe together on adv.
  logic [ANGLE_BITS-1:0] a1, a2, a3;
  assign a1 = in_joint_one_angle;
  assign a2 = in_joint_one_angle + in_joint_two_angle;
  assign a3 = a2 + in_joint_three_angle;

  always_ff @(posedge clk) begin
    if (adv) begin
      ang_r[0] <= a1; ang_r[1] <= a2; ang_r[2] <= a3;
      head_r[0] <= a3;
      for (int k = 1; k < LAT; k++) head_r[k] <= head_r[k-1];
    end
  end

  for (genvar j = 0; j < 3; j++) begin : g_trig
    p3a_trig #(.ANGLE_BITS(ANGLE_BITS), .TRIG_STAGES(TRIG_STAGES)) u_trig (
      .clk(clk), .en(adv), .angle(ang_r[j]), .cos_q15(cs[j]), .sin_q15(sn[j]));
    always_ff @(posedge clk) begin
      if (adv) begin
        px_r[j] <= (PW'($signed({1'b0, len_r[j]})) * PW'(cs[j]) + RND) >>> 15;
        py_r[j] <= (PW'($signed({1'b0, len_r[j]})) * PW'(sn[j]) + RND) >>> 15;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      sx_r <= (LENGTH_BITS+3)'(px_r[0] + px_r[1] + px_r[2]);
      sy_r <= (LENGTH_BITS+3)'(py_r[0] + py_r[1] + py_r[2]);
    end
  end

  assign out_pose_x = sx_r;
  assign out_pose_y = sy_r;
  assign out_pose_heading = head_r[LAT-1];

`ifndef ASSERT_OFF
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_pose_x))
    else $error("pose word changed under stall");
  a_ready: assert property (@(posedge clk) disable iff (!rst_n)
    !out_valid |-> !in_stall) else $error("stall without pending word");
  a_head: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> $stable(out_pose_heading))
    else $error("heading changed under stall");
`endif

endmodule

[hdl/p3a_cell.sv]
// ----------------------------------------------------------------------------
// p3a_cell
// One CORDIC micro-rotation stage; registers the rotated word for its neighbor.
// ----------------------------------------------------------------------------
module p3a_cell #(
  parameter int IDX = 0
) (
  input  logic           clk,
  input  logic           en,
  input  p3a_pkg::p3a_rot_t rot_in,
  output p3a_pkg::p3a_rot_t rot_out
);

  p3a_pkg::p3a_rot_t rot_nxt;
  logic signed [p3a_pkg::CORDIC_W-1:0] dx;
  logic signed [p3a_pkg::CORDIC_W-1:0] dy;

  always_comb begin
    dx = rot_in.y >>> IDX;
    dy = rot_in.x >>> IDX;
    if (!rot_in.z[32]) begin
      rot_nxt.x = rot_in.x - dx;
      rot_nxt.y = rot_in.y + dy;
      rot_nxt.z = rot_in.z - p3a_pkg::atan_phase(IDX);
    end else begin
      rot_nxt.x = rot_in.x + dx;
      rot_nxt.y = rot_in.y - dy;
      rot_nxt.z = rot_in.z + p3a_pkg::atan_phase(IDX);
    end
  end

  always_ff @(posedge clk) begin
    if (en) rot_out <= rot_nxt;
  end

endmodule

[hdl/p3a_trig.sv]
// ----------------------------------------------------------------------------
// p3a_trig
// Pipelined CORDIC: quadrant fold, chain of rotation cells, Q1.15 rounding.
// ----------------------------------------------------------------------------
module p3a_trig #(
  parameter int ANGLE_BITS  = p3a_pkg::ANGLE_BITS_DEF,
  parameter int TRIG_STAGES = p3a_pkg::TRIG_STAGES_DEF
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [ANGLE_BITS-1:0] angle,
  output logic signed [15:0]    cos_q15,
  output logic signed [15:0]    sin_q15
);

  localparam int STAGES = (TRIG_STAGES < p3a_pkg::ATAN_ENTRIES) ?
                          TRIG_STAGES : p3a_pkg::ATAN_ENTRIES;
  localparam logic signed [32:0] QTR = 33'sd1073741824;
  localparam logic signed [32:0] HALF = 33'sd2147483648;

  logic [31:0] phase;
  logic signed [32:0] z0;
  logic signed [32:0] zf;
  logic flip;
  p3a_pkg::p3a_rot_t rot_r;
  p3a_pkg::p3a_rot_t chain [STAGES];
  p3a_pkg::p3a_rot_t rot_nxt;
  logic flip_pipe_r [STAGES+1];
  logic signed [p3a_pkg::CORDIC_W-1:0] xo;
  logic signed [p3a_pkg::CORDIC_W-1:0] yo;

  function automatic logic signed [15:0] rnd(input logic signed [p3a_pkg::CORDIC_W-1:0] v);
    logic signed [p3a_pkg::CORDIC_W:0] s;
    logic signed [p3a_pkg::CORDIC_W:0] r;
    s = {v[p3a_pkg::CORDIC_W-1], v} + 35'sd16384;
    r = s >>> 15;
    if (r > 35'sd32767) return 16'sh7fff;
    if (r < -35'sd32768) return 16'sh8000;
    return r[15:0];
  endfunction

  always_comb begin
    phase = {angle, {(32-ANGLE_BITS){1'b0}}};
    z0 = {phase[31], phase};
    flip = 1'b0;
    zf = z0;
    if (z0 > QTR || z0 < -QTR) begin
      zf = z0[32] ? z0 + HALF : z0 - HALF;
      flip = 1'b1;
    end else if (z0 == QTR) begin
      zf = -QTR;
      flip = 1'b1;
    end
    rot_nxt.x = p3a_pkg::CORDIC_GAIN;
    rot_nxt.y = '0;
    rot_nxt.z = zf;
  end

  always_ff @(posedge clk) begin
    if (en) begin
      rot_r <= rot_nxt;
      flip_pipe_r[0] <= flip;
      for (int k = 1; k <= STAGES; k++) flip_pipe_r[k] <= flip_pipe_r[k-1];
    end
  end

  for (genvar g = 0; g < STAGES; g++) begin : g_cell
    if (g == 0) begin : g_first
      p3a_cell #(.IDX(g)) u_cell (.clk(clk), .en(en), .rot_in(rot_r), .rot_out(chain[g]));
    end else begin : g_rest
      p3a_cell #(.IDX(g)) u_cell (.clk(clk), .en(en), .rot_in(chain[g-1]),
        .rot_out(chain[g]));
    end
  end

  assign xo = flip_pipe_r[STAGES] ? -chain[STAGES-1].x : chain[STAGES-1].x;
  assign yo = flip_pipe_r[STAGES] ? -chain[STAGES-1].y : chain[STAGES-1].y;

  always_ff @(posedge clk) begin
    if (en) begin
      cos_q15 <= rnd(xo);
      sin_q15 <= rnd(yo);
    end
  end

endmodule

[dv/planar_three_joint_arm_pose_top_test.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// planar_three_joint_arm_pose_top_test
// Checks the arm pose block against a CORDIC-based pose predictor.
// Joint words go in through a queued driver and pose words are compared in
// order by a monitor. The link lengths change between phases, and both
// sides idle at random in four of the six phases.
// ----------------------------------------------------------------------------
module planar_three_joint_arm_pose_top_test;

  typedef struct packed {
    logic signed [15:0] j1;
    logic signed [15:0] j2;
    logic signed [15:0] j3;
  } joint_word_t;

  typedef struct packed {
    logic signed [18:0] px;
    logic signed [18:0] py;
    logic signed [15:0] hd;
  } pose_word_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_we = 1'b0;
  logic [1:0] cfg_index = p3a_pkg::REG_LINK_ONE;
  logic [15:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_stall;
  logic signed [15:0] in_joint_one_angle = '0;
  logic signed [15:0] in_joint_two_angle = '0;
  logic signed [15:0] in_joint_three_angle = '0;
  logic out_valid;
  logic out_stall = 1'b0;
  logic signed [18:0] out_pose_x;
  logic signed [18:0] out_pose_y;
  logic signed [15:0] out_pose_heading;

  planar_three_joint_arm_pose_top dut (.*);

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  joint_word_t pending_joints[$];
  pose_word_t expected_poses[$];
  logic [15:0] link_len[3];
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int mismatches = 0;
  longint cycles = 0;

  localparam int ATAN_TAB[24] = '{536870912, 316933406, 167458907, 85004756, 42667331,
    21354465, 10680862, 5340245, 2670163, 1335087, 667544, 333772, 166886, 83443,
    41722, 20861, 10430, 5215, 2608, 1304, 652, 326, 163, 81};

  function automatic longint q15_round(longint v);
    longint r;
    r = (v + 16384) >>> 15;
    if (r > 32767) r = 32767;
    if (r < -32768) r = -32768;
    return r;
  endfunction

  function automatic void trig_of(input logic [15:0] ang, output longint c,
                                  output longint s);
    longint z, x, y, dx, dy;
    bit flip;
    z = longint'({ang, 16'h0});
    x = 652032874;
    y = 0;
    flip = 0;
    if (z >= (64'sd1 << 31)) z -= (64'sd1 << 32);
    if (z > (64'sd1 << 30) || z < -(64'sd1 << 30)) begin
      z += (z >= 0) ? -(64'sd1 << 31) : (64'sd1 << 31);
      flip = 1;
    end else if (z == (64'sd1 << 30)) begin
      z = -(64'sd1 << 30);
      flip = 1;
    end
    for (int i = 0; i < 16; i++) begin
      dx = y >>> i;
      dy = x >>> i;
      if (z >= 0) begin
        x -= dx; y += dy; z -= ATAN_TAB[i];
      end else begin
        x += dx; y -= dy; z += ATAN_TAB[i];
      end
    end
    if (flip) begin
      x = -x;
      y = -y;
    end
    c = q15_round(x);
    s = q15_round(y);
  endfunction

  function automatic pose_word_t predict_pose(joint_word_t j);
    pose_word_t p;
    logic [15:0] b[3];
    longint c, s, sx, sy;
    b[0] = j.j1;
    b[1] = b[0] + j.j2;
    b[2] = b[1] + j.j3;
    sx = 0;
    sy = 0;
    for (int k = 0; k < 3; k++) begin
      trig_of(b[k], c, s);
      sx += (longint'(link_len[k]) * c + 16384) >>> 15;
      sy += (longint'(link_len[k]) * s + 16384) >>> 15;
    end
    p.px = sx[18:0];
    p.py = sy[18:0];
    p.hd = b[2];
    return p;
  endfunction

  task automatic report_mismatch(input string what, input longint got, input longint want);
    $display("mismatch %s: got %0d expected %0d at cycle %0d", what, got, want, cycles);
    mismatches++;
  endtask

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > 400000) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // driver
  always @(posedge clk) begin
    if (rst_n) begin
      if (!in_valid || !in_stall) begin
        if (in_valid) expected_poses.push_back(predict_pose({in_joint_one_angle,
          in_joint_two_angle, in_joint_three_angle}));
        if (pending_joints.size() > 0 && $urandom_range(99) >= send_idle_pct) begin
          joint_word_t w;
          w = pending_joints.pop_front();
          in_valid <= 1'b1;
          in_joint_one_angle <= w.j1;
          in_joint_two_angle <= w.j2;
          in_joint_three_angle <= w.j3;
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // monitor
  always @(posedge clk) begin
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        if (expected_poses.size() == 0) begin
          report_mismatch("unexpected word", 0, 0);
        end else begin
          pose_word_t e;
          e = expected_poses.pop_front();
          if (out_pose_x !== e.px) report_mismatch("pose_x", out_pose_x, e.px);
          if (out_pose_y !== e.py) report_mismatch("pose_y", out_pose_y, e.py);
          if (out_pose_heading !== e.hd)
            report_mismatch("pose_heading", out_pose_heading, e.hd);
        end
      end
      out_stall <= ($urandom_range(99) < recv_idle_pct);
    end
  end

  task automatic write_link(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    link_len[idx] = val;
  endtask

  task automatic drain();
    @(negedge clk);
    while (pending_joints.size() > 0 || in_valid || expected_poses.size() > 0)
      @(negedge clk);
    repeat (40) @(posedge clk);
  endtask

  function automatic logic [15:0] rand_angle();
    case ($urandom_range(7))
      0: return 16'h8000;
      1: return 16'h4000;
      2: return 16'hC000;
      3: return 16'h0000;
      4: return 16'h7FFF;
      default: return 16'($urandom());
    endcase
  endfunction

  task automatic fill_random(input int n);
    joint_word_t w;
    for (int i = 0; i < n; i++) begin
      w.j1 = rand_angle();
      w.j2 = rand_angle();
      w.j3 = rand_angle();
      pending_joints.push_back(w);
    end
  endtask

  initial begin
    logic [15:0] edge_ang[6];
    joint_word_t w;
    edge_ang = '{16'h0000, 16'h4000, 16'h8000, 16'hC000, 16'h7FFF, 16'h8001};
    link_len = '{16'd0, 16'd0, 16'd0};
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    write_link(p3a_pkg::REG_LINK_ONE, 16'hFFFF);
    write_link(p3a_pkg::REG_LINK_TWO, 16'hFFFF);
    write_link(p3a_pkg::REG_LINK_THREE, 16'hFFFF);
    for (int i = 0; i < 6; i++) begin
      w.j1 = edge_ang[i];
      w.j2 = edge_ang[(i + 1) % 6];
      w.j3 = edge_ang[(i + 3) % 6];
      pending_joints.push_back(w);
    end
    pending_joints.push_back({16'h7FFF, 16'h0001, 16'h0000});
    pending_joints.push_back({16'h4000, 16'h4000, 16'h0000});
    pending_joints.push_back({16'hFFFF, 16'hFFFF, 16'hFFFF});
    pending_joints.push_back({16'h2000, 16'h6000, 16'hA000});
    drain();
    for (int ph = 0; ph < 6; ph++) begin
      case (ph % 3)
        0: begin send_idle_pct = 27; recv_idle_pct = 54; end
        1: begin send_idle_pct = 54; recv_idle_pct = 27; end
        default: begin send_idle_pct = 0; recv_idle_pct = 0; end
      endcase
      write_link(p3a_pkg::REG_LINK_ONE, ph == 5 ? 16'h0000 : 16'($urandom()));
      write_link(p3a_pkg::REG_LINK_TWO, ph == 5 ? 16'hFFFF : 16'($urandom()));
      write_link(p3a_pkg::REG_LINK_THREE, ph == 4 ? 16'h0000 : 16'($urandom()));
      fill_random(320);
      drain();
    end
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
